/* rtl/pdfc_pkg.sv */
// Shared types and constants of the pixel delta fold codec.
package pdfc_pkg;

	localparam int DEF_MAX_CHANNELS = 4;
	localparam int SAMPLE_W = 8;
	localparam int HIST_W = 7;
	localparam int COUNT_W = 3;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic REG_DECODE_MODE = 1'b0;
	localparam logic REG_CHANNEL_COUNT = 1'b1;

	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	typedef struct packed {
		logic decode_mode;
		logic [COUNT_W-1:0] channel_count;
	} cfg_t;

endpackage

/* rtl/pdfc_cfg_regs.sv */
// APB-style configuration registers of the pixel delta fold codec.
module pdfc_cfg_regs (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [pdfc_pkg::APB_ADDR_W-1:0] paddr,
	input logic [pdfc_pkg::APB_DATA_W-1:0] pwdata,
	output logic [pdfc_pkg::APB_DATA_W-1:0] prdata,
	output logic pready,
	output pdfc_pkg::cfg_t cfg
);
	import pdfc_pkg::*;

	logic decode_mode_q;
	logic [COUNT_W-1:0] channel_count_q;
	logic wr_en;
	logic reg_sel;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decode_mode_q <= MODE_ENCODE;
			channel_count_q <= COUNT_W'(1);
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_DECODE_MODE: decode_mode_q <= pwdata[0];
				REG_CHANNEL_COUNT: channel_count_q <= pwdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			REG_DECODE_MODE: prdata[0] = decode_mode_q;
			REG_CHANNEL_COUNT: prdata[COUNT_W-1:0] = channel_count_q;
			default: prdata = '0;
		endcase
	end

	assign cfg.decode_mode = decode_mode_q;
	assign cfg.channel_count = channel_count_q;

endmodule

/* rtl/pdfc_calc.sv */
// Channel history, sample counter, delta coding logic and result register.
module pdfc_calc #(
	parameter int MAX_CHANNELS = pdfc_pkg::DEF_MAX_CHANNELS
) (
	input logic clk,
	input logic arst_n,
	input pdfc_pkg::cfg_t cfg,
	input logic load,
	input logic [pdfc_pkg::SAMPLE_W-1:0] sample_s1,
	input logic start_s1,
	input logic result_ready,
	output logic result_valid,
	output logic [pdfc_pkg::SAMPLE_W-1:0] result
);
	import pdfc_pkg::*;

	localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
	localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	logic [HIST_W-1:0] hist_q [MAX_CHANNELS];
	logic [CNT_W-1:0] seen_q;
	logic [CNT_W-1:0] seen_base;
	logic [CNT_W-1:0] cc;
	logic [CNT_W-1:0] cc_m1;
	logic first;
	logic [HIST_W-1:0] prev;
	logic [HIST_W-1:0] v;
	logic [HIST_W:0] diff;
	logic [HIST_W-1:0] unfold;
	logic [SAMPLE_W-1:0] res;
	logic valid_s2;
	logic [SAMPLE_W-1:0] result_s2;

	always_comb begin
		if (cfg.channel_count == '0) begin
			cc = CNT_W'(1);
		end else if (32'(cfg.channel_count) > MAX_CHANNELS) begin
			cc = CNT_W'(MAX_CHANNELS);
		end else begin
			cc = CNT_W'(cfg.channel_count);
		end
	end

	assign cc_m1 = cc - CNT_W'(1);
	assign seen_base = start_s1 ? '0 : seen_q;
	assign first = seen_base < cc;
	assign prev = hist_q[cc_m1[IDX_W-1:0]];

	always_comb begin
		diff = {1'b0, sample_s1[SAMPLE_W-1:1]} - {1'b0, prev};
		unfold = sample_s1[SAMPLE_W-1:1] ^ {HIST_W{sample_s1[0]}};
		unique case (cfg.decode_mode)
			MODE_ENCODE: begin
				v = sample_s1[SAMPLE_W-1:1];
				if (first) begin
					res = {1'b0, v};
				end else begin
					res = {diff[HIST_W-1:0], 1'b0} ^ {SAMPLE_W{diff[HIST_W]}};
				end
			end
			MODE_DECODE: begin
				if (first) begin
					v = sample_s1[HIST_W-1:0];
				end else begin
					v = prev + unfold;
				end
				res = {v, 1'b0};
			end
			default: begin
				v = '0;
				res = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q[0] <= '0;
			seen_q <= '0;
		end else if (load) begin
			hist_q[0] <= v;
			if (32'(seen_base) < MAX_CHANNELS) begin
				seen_q <= seen_base + CNT_W'(1);
			end else begin
				seen_q <= seen_base;
			end
		end
	end

	for (genvar k = 1; k < MAX_CHANNELS; k++) begin : g_hist
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				hist_q[k] <= '0;
			end else if (load) begin
				hist_q[k] <= hist_q[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_s2 <= res;
		end
	end

	assign result_valid = valid_s2;
	assign result = result_s2;

	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(seen_q) <= MAX_CHANNELS)
		else $error("sample counter above channel limit");

	a_start_count: assert property (@(posedge clk) disable iff (!arst_n)
		load && start_s1 |=> seen_q == CNT_W'(1))
		else $error("image start did not restart the sample counter");

	a_decode_even: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && cfg.decode_mode == MODE_DECODE |-> !result_s2[0])
		else $error("decoded pixel byte is odd");

	a_load_room: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !valid_s2 || result_ready)
		else $error("result register overwritten while held");

endmodule

/* rtl/pixel_delta_fold_codec_core.sv */
// Top level of the pixel delta fold codec: input register and block wiring.
//
// Samples enter on the sample channel (sample, image_start, sample_valid,
// sample_ready) and leave on the result channel (result, result_valid,
// result_ready); each beat in gives exactly one beat out, in order.
// A beat passes an input register and then the coding logic into the result
// register, from which its result is offered.
// One beat is accepted per cycle while the receiver keeps up; the rate is set
// by the history update between the two registers. When the receiver stalls,
// the result register holds its beat, one more beat waits in the input
// register, and sample_ready then falls. Setting image_start on a beat
// restarts the per-channel history count. Reset clears the history, the count
// and both valid flags, and sets encode mode with one channel. Registers are
// written through the APB port (decode_mode at 0x0, channel_count at 0x4) by
// the user only while the block is idle; the block does not enforce this.
module pixel_delta_fold_codec_core #(
	parameter int MAX_CHANNELS = pdfc_pkg::DEF_MAX_CHANNELS
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [pdfc_pkg::APB_ADDR_W-1:0] paddr,
	input logic [pdfc_pkg::APB_DATA_W-1:0] pwdata,
	output logic [pdfc_pkg::APB_DATA_W-1:0] prdata,
	output logic pready,
	input logic sample_valid,
	output logic sample_ready,
	input logic [pdfc_pkg::SAMPLE_W-1:0] sample,
	input logic image_start,
	output logic result_valid,
	input logic result_ready,
	output logic [pdfc_pkg::SAMPLE_W-1:0] result
);
	import pdfc_pkg::*;

	cfg_t cfg;
	logic valid_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic start_s1;
	logic load;

	pdfc_cfg_regs u_cfg_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	assign load = valid_s1 && (!result_valid || result_ready);
	assign sample_ready = !valid_s1 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			sample_s1 <= sample;
			start_s1 <= image_start;
		end
	end

	pdfc_calc #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_calc (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.load(load),
		.sample_s1(sample_s1),
		.start_s1(start_s1),
		.result_ready(result_ready),
		.result_valid(result_valid),
		.result(result)
	);

endmodule

/* sim/pixel_delta_fold_codec_core_tb.sv */
// Self-checking testbench for the pixel delta fold codec with an in-order predictor of the result codes.
module pixel_delta_fold_codec_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pdfc_pkg::*;

	localparam int CH_MAX = DEF_MAX_CHANNELS;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;
	logic sample_valid = 1'b0;
	logic sample_ready;
	logic [SAMPLE_W-1:0] sample = '0;
	logic image_start = 1'b0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic [SAMPLE_W-1:0] result;

	logic [HIST_W-1:0] pixel_history [CH_MAX];
	int unsigned samples_since_start = 0;
	logic coding_mode = MODE_ENCODE;
	logic [COUNT_W-1:0] channels_reg = 3'd1;

	logic [SAMPLE_W-1:0] expected_codes [$];
	logic [SAMPLE_W-1:0] want_code;
	int unsigned snd_idle_pct = 0;
	int unsigned rcv_stall_pct = 0;
	int unsigned hold_cycles = 0;
	int error_count = 0;
	longint cycle_count = 0;

	pixel_delta_fold_codec_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample),
		.image_start(image_start),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		for (int k = 0; k < CH_MAX; k++) begin
			pixel_history[k] = '0;
		end
	end

	function automatic logic [SAMPLE_W-1:0] code_sample(input logic [SAMPLE_W-1:0] s,
			input logic st);
		int unsigned n;
		logic [HIST_W-1:0] prev;
		logic [HIST_W-1:0] v;
		logic [HIST_W-1:0] delta;
		int d;
		logic first;
		logic [SAMPLE_W-1:0] code;
		n = channels_reg;
		if (n < 1) n = 1;
		if (n > CH_MAX) n = CH_MAX;
		if (st) samples_since_start = 0;
		first = (samples_since_start < n);
		prev = pixel_history[n-1];
		if (coding_mode == MODE_ENCODE) begin
			v = s[7:1];
			if (first) begin
				code = {1'b0, v};
			end else begin
				d = int'(v) - int'(prev);
				code = (d < 0) ? 8'(-2 * d - 1) : 8'(2 * d);
			end
		end else begin
			if (first) begin
				v = s[6:0];
			end else begin
				if (s[0]) delta = 7'(128 - ((int'(s) + 1) >> 1));
				else delta = s[7:1];
				v = prev + delta;
			end
			code = {v, 1'b0};
		end
		for (int k = CH_MAX - 1; k > 0; k--) begin
			pixel_history[k] = pixel_history[k-1];
		end
		pixel_history[0] = v;
		if (samples_since_start < CH_MAX) samples_since_start++;
		return code;
	endfunction

	task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] got,
			input logic [SAMPLE_W-1:0] want);
		$display("%0t mismatch: %s got %02h want %02h", $realtime, what, got, want);
		error_count++;
	endtask

	task automatic send_beat(input logic [SAMPLE_W-1:0] s, input logic st);
		while (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		image_start <= st;
		do @(posedge clk); while (!sample_ready);
		expected_codes.push_back(code_sample(s, st));
	endtask

	task automatic drain_results();
		sample_valid <= 1'b0;
		while (expected_codes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [APB_DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_DECODE_MODE) coding_mode = value[0];
		else channels_reg = value[COUNT_W-1:0];
	endtask

	// The first beats carry no image start, so the count runs from reset.
	task automatic test_encode_extremes();
		send_beat(8'h00, 1'b0);
		send_beat(8'hFF, 1'b0);
		send_beat(8'h00, 1'b0);
		send_beat(8'h01, 1'b0);
		send_beat(8'hFE, 1'b0);
		send_beat(8'h80, 1'b0);
		send_beat(8'h7F, 1'b0);
		send_beat(8'hFF, 1'b1);
		drain_results();
	endtask

	task automatic test_decode_codes();
		write_reg(REG_DECODE_MODE, APB_DATA_W'(MODE_DECODE));
		write_reg(REG_CHANNEL_COUNT, 32'd3);
		send_beat(8'hFF, 1'b1);
		send_beat(8'h00, 1'b0);
		send_beat(8'h80, 1'b0);
		send_beat(8'hFF, 1'b0);
		send_beat(8'hFE, 1'b0);
		send_beat(8'h01, 1'b0);
		drain_results();
	endtask

	// Count and mode change without an image start, so the history carries over.
	task automatic test_channel_limits();
		write_reg(REG_CHANNEL_COUNT, 32'd0);
		send_beat(8'h33, 1'b0);
		send_beat(8'hC4, 1'b0);
		drain_results();
		write_reg(REG_CHANNEL_COUNT, 32'd7);
		send_beat(8'h55, 1'b0);
		send_beat(8'hAA, 1'b0);
		send_beat(8'h0F, 1'b0);
		drain_results();
		write_reg(REG_DECODE_MODE, APB_DATA_W'(MODE_ENCODE));
		send_beat(8'h9C, 1'b0);
		send_beat(8'h21, 1'b0);
		drain_results();
		write_reg(REG_CHANNEL_COUNT, 32'd4);
		send_beat(8'h6E, 1'b0);
		send_beat(8'hF1, 1'b0);
		drain_results();
	endtask

	task automatic test_backpressure();
		snd_idle_pct = 0;
		rcv_stall_pct = 0;
		write_reg(REG_CHANNEL_COUNT, 32'd2);
		hold_cycles = 150;
		for (int i = 0; i < 30; i++) begin
			send_beat(8'($urandom_range(255)), i == 0);
		end
		drain_results();
	endtask

	task automatic test_random_images(input int unsigned snd_pct, input int unsigned rcv_pct,
			input int unsigned total);
		int unsigned sent;
		int unsigned seg_end;
		int unsigned img_left;
		logic [SAMPLE_W-1:0] pix;
		logic st;
		snd_idle_pct = snd_pct;
		rcv_stall_pct = rcv_pct;
		sent = 0;
		pix = 8'($urandom_range(255));
		while (sent < total) begin
			drain_results();
			write_reg(REG_DECODE_MODE, $urandom_range(1));
			write_reg(REG_CHANNEL_COUNT, $urandom_range(7));
			seg_end = sent + $urandom_range(50, 100);
			img_left = 0;
			while (sent < seg_end && sent < total) begin
				st = 1'b0;
				if (img_left == 0) begin
					img_left = $urandom_range(1, 40);
					st = ($urandom_range(9) != 0);
				end else if ($urandom_range(49) == 0) begin
					st = 1'b1;
				end
				img_left--;
				if ($urandom_range(3) == 0) pix = 8'($urandom_range(255));
				else pix = pix + 8'($urandom_range(16)) - 8'd8;
				send_beat(pix, st);
				sent++;
			end
		end
		drain_results();
	endtask

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			result_ready <= 1'b0;
			hold_cycles--;
		end else if (rcv_stall_pct != 0 && $urandom_range(99) < rcv_stall_pct) begin
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (expected_codes.size() == 0) begin
				report_mismatch("unexpected result beat", result, 8'h00);
			end else begin
				want_code = expected_codes.pop_front();
				if (result !== want_code) report_mismatch("result", result, want_code);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[pixel_delta_fold_codec_core] ERROR");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_encode_extremes();
		test_decode_codes();
		test_channel_limits();
		test_backpressure();
		test_random_images(0, 0, 330);
		test_random_images(77, 0, 330);
		test_random_images(0, 77, 330);
		test_random_images(21, 21, 330);
		rcv_stall_pct = 0;
		repeat (8) @(posedge clk);
		if (error_count == 0 && expected_codes.size() == 0) begin
			$display("[pixel_delta_fold_codec_core] OK");
		end else begin
			$display("[pixel_delta_fold_codec_core] ERROR");
		end
		$finish;
	end

endmodule
